### rtl/bfbp_pkg.sv
`timescale 1ns / 1ps

package bfbp_pkg;

  // Default sizes of the pool
  localparam int DEF_POOL_ENTRIES = 128;
  localparam int DEF_SIZE_BITS    = 32;
  localparam int DEF_HANDLE_BITS  = 32;

  // Request operations
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_REUSED      = 3'd0;
  localparam logic [2:0] ST_NEW_REG     = 3'd1;
  localparam logic [2:0] ST_NEW_FULL    = 3'd2;
  localparam logic [2:0] ST_CREATE_FAIL = 3'd3;
  localparam logic [2:0] ST_RELEASED    = 3'd4;
  localparam logic [2:0] ST_FREE_DIRECT = 3'd5;
  localparam logic [2:0] ST_CLEARED     = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] request_size;
    logic        copy_host;
    logic [31:0] buffer_handle;
    logic        create_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_handle;
    logic [6:0]  entry_index;
  } rsp_t;

endpackage

### rtl/best_fit_buffer_pool_top.sv
`timescale 1ns / 1ps

// An allocate scans the registered records for the smallest free record that fits; a release
// scans until a record holds its handle or none is left. The scan reads one record a cycle.
// A copy allocation or a request on an empty pool skips the scan; a clear needs no scan.
// One request at a time: the next request is taken the cycle after the result is delivered.
// Reset (synchronous, active high) empties the pool; record contents are not cleared.
module best_fit_buffer_pool_top #(
  parameter int POOL_ENTRIES = bfbp_pkg::DEF_POOL_ENTRIES,
  parameter int SIZE_BITS    = bfbp_pkg::DEF_SIZE_BITS,
  parameter int HANDLE_BITS  = bfbp_pkg::DEF_HANDLE_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bfbp_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bfbp_pkg::rsp_t out_data
);

  import bfbp_pkg::*;

  localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  typedef struct packed {
    logic                   busy;
    logic [SIZE_BITS-1:0]   size;
    logic [HANDLE_BITS-1:0] handle;
  } rec_t;

  // Record memory
  rec_t mem [POOL_ENTRIES];
  rec_t rd_data;
  logic             we;
  logic [IDX_W-1:0] waddr;
  rec_t             wdata;

  logic [1:0]             state;
  logic [CNT_W-1:0]       entry_count;
  logic [CNT_W-1:0]       addr;
  logic                   rd_valid;
  logic [IDX_W-1:0]       rd_tag;
  logic [1:0]             op;
  logic                   created;
  logic [SIZE_BITS-1:0]   req_size;
  logic [HANDLE_BITS-1:0] req_handle;
  logic                   found;
  logic [IDX_W-1:0]       best;
  logic [SIZE_BITS-1:0]   fit_size;
  logic [HANDLE_BITS-1:0] best_handle;
  rsp_t                   rsp;

  logic [63:0] size_wide;
  logic [63:0] handle_wide;
  logic        issuing;
  logic        scan_done;
  logic        fits;
  logic        hit;
  logic        full;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = rsp;

  assign size_wide   = 64'(in_data.request_size);
  assign handle_wide = 64'(in_data.buffer_handle);

  assign issuing   = (addr < entry_count);
  assign scan_done = !issuing && !rd_valid;
  assign full      = (entry_count >= CNT_W'(POOL_ENTRIES));

  // Shared compare unit on the record just read
  assign fits = rd_valid && !rd_data.busy && (rd_data.size >= req_size) &&
                (!found || (rd_data.size < fit_size));
  assign hit  = rd_valid && (rd_data.handle == req_handle);

  // Narrow a record index or handle onto the result fields
  function automatic logic [6:0] to_index(input logic [IDX_W-1:0] idx);
    logic [15:0] wide;
    wide = 16'(idx);
    return wide[6:0];
  endfunction

  function automatic logic [31:0] to_handle(input logic [HANDLE_BITS-1:0] h);
    logic [63:0] wide;
    wide = 64'(h);
    return wide[31:0];
  endfunction

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[addr[IDX_W-1:0]];
  end

  // Select the memory write
  always_comb begin
    we    = 1'b0;
    waddr = best;
    wdata = '{busy: 1'b1, size: fit_size, handle: best_handle};
    if (state == S_SCAN) begin
      if (op == OP_RELEASE && hit) begin
        we    = 1'b1;
        waddr = rd_tag;
        wdata = '{busy: 1'b0, size: rd_data.size, handle: rd_data.handle};
      end else if (op == OP_ALLOC && scan_done) begin
        if (found) begin
          we = 1'b1;
        end else if (created && !full) begin
          we    = 1'b1;
          waddr = entry_count[IDX_W-1:0];
          wdata = '{busy: 1'b1, size: req_size, handle: req_handle};
        end
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rd_valid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_valid <= 1'b0;
          if (in_valid) begin
            op         <= in_data.operation;
            created    <= in_data.create_ok;
            req_size   <= size_wide[SIZE_BITS-1:0];
            req_handle <= handle_wide[HANDLE_BITS-1:0];
            found      <= 1'b0;
            best       <= '0;
            fit_size   <= '0;
            best_handle <= '0;
            // Skip the scan for a copy allocation
            if (in_data.operation == OP_ALLOC && in_data.copy_host) begin
              addr <= entry_count;
            end else begin
              addr <= '0;
            end
            case (in_data.operation)
              OP_ALLOC, OP_RELEASE: state <= S_SCAN;
              OP_CLEAR: begin
                entry_count <= '0;
                rsp         <= '{status: ST_CLEARED, result_handle: '0, entry_index: '0};
                state       <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          // Issue the next read
          rd_valid <= issuing;
          rd_tag   <= addr[IDX_W-1:0];
          if (issuing) begin
            addr <= addr + CNT_W'(1);
          end
          // Track the best fit
          if (op == OP_ALLOC && fits) begin
            found       <= 1'b1;
            best        <= rd_tag;
            fit_size    <= rd_data.size;
            best_handle <= rd_data.handle;
          end
          if (op == OP_RELEASE && hit) begin
            rsp   <= '{status: ST_RELEASED, result_handle: '0, entry_index: to_index(rd_tag)};
            state <= S_OUT;
          end else if (scan_done) begin
            state <= S_OUT;
            if (op == OP_RELEASE) begin
              rsp <= '{status: ST_FREE_DIRECT, result_handle: '0, entry_index: '0};
            end else if (found) begin
              rsp <= '{status: ST_REUSED, result_handle: to_handle(best_handle),
                       entry_index: to_index(best)};
            end else if (!created) begin
              rsp <= '{status: ST_CREATE_FAIL, result_handle: '0, entry_index: '0};
            end else if (!full) begin
              entry_count <= entry_count + CNT_W'(1);
              rsp <= '{status: ST_NEW_REG, result_handle: to_handle(req_handle),
                       entry_index: to_index(entry_count[IDX_W-1:0])};
            end else begin
              rsp <= '{status: ST_NEW_FULL, result_handle: to_handle(req_handle),
                       entry_index: '0};
            end
          end
        end
        S_OUT: begin
          rd_valid <= 1'b0;
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
